>>> rtl/sha0_pkg.sv
// Shared types, constants and command/status structs for the SHA-0 hasher.
package sha0_pkg;

  localparam int WORD_W    = 32;
  localparam int NUM_H     = 5;
  localparam int BLK_WORDS = 16;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [5:0] LEN_POS        = 6'd56;
  localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
  localparam logic [6:0] ROUND_LAST     = 7'd79;
  localparam logic [2:0] LAST_WORD      = 3'd4;

  localparam logic [WORD_W-1:0] INIT_H [NUM_H] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  // Source of the byte placed into the block buffer
  typedef enum logic [1:0] {
    BSEL_IN   = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } byte_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      put_byte;
    byte_sel_t byte_sel;
    logic      count_len;
    logic      load_rounds;
    logic      round_step;
    logic      add_chain;
    logic      load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_last;
    logic pos_len;
    logic round_last;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/sha0_if.sv
// Valid/ready channel interfaces for message input and digest output.
interface sha0_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] message_byte;

  modport source (output valid, operation, message_byte, input ready);
  modport sink   (input valid, operation, message_byte, output ready);
endinterface

interface sha0_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  modport source (output valid, digest_word, word_number, final_word, input ready);
  modport sink   (input valid, digest_word, word_number, final_word, output ready);
endinterface

>>> rtl/sha0_dp.sv
// Datapath: block buffer / schedule window, round unit, chaining words, digest buffer.
module sha0_dp (
  input  logic             clk,
  input  logic             rst,
  input  sha0_pkg::dp_cmd_t  cmd,
  output sha0_pkg::dp_stat_t stat,
  input  logic [7:0]       message_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_number,
  output logic             final_word
);
  import sha0_pkg::*;

  // Control state
  logic [5:0]        pos;
  logic [63:0]       bit_length;
  logic [WORD_W-1:0] h [NUM_H];
  logic              ovalid;
  logic [2:0]        onum;

  // Payload state
  logic [WORD_W-1:0] win  [BLK_WORDS];
  logic [WORD_W-1:0] obuf [NUM_H];
  logic [WORD_W-1:0] ra, rb, rc, rd, re;
  logic [6:0]        t;

  // Byte placement
  logic [3:0]        idx;
  logic [7:0]        len_byte;
  logic [7:0]        byte_val;
  logic [WORD_W-1:0] placed;
  logic [WORD_W-1:0] word_new;

  // Round logic
  logic [WORD_W-1:0] w_t;
  logic [WORD_W-1:0] f_t;
  logic [WORD_W-1:0] k_t;
  logic [WORD_W-1:0] tmp;

  assign idx      = pos[5:2];
  assign len_byte = 8'(bit_length >> {~pos[2:0], 3'b000});

  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_IN:   byte_val = message_byte;
      BSEL_PAD:  byte_val = PAD_BYTE;
      BSEL_ZERO: byte_val = 8'h00;
      BSEL_LEN:  byte_val = len_byte;
      default:   byte_val = 8'h00;
    endcase
  end

  // Big-endian byte lane; first byte of a word clears the rest
  assign placed   = WORD_W'(byte_val) << {~pos[1:0], 3'b000};
  assign word_new = (pos[1:0] == 2'b00) ? placed : (win[idx] | placed);

  // Schedule: window[0] is W[t-16] once t >= 16
  assign w_t = (t < 7'd16) ? win[0] : (win[13] ^ win[8] ^ win[2] ^ win[0]);

  // Round function and constant by round group
  always_comb begin
    priority if (t < 7'd20) begin
      f_t = (rb & rc) | (~rb & rd);
      k_t = ROUND_K[0];
    end else if (t < 7'd40) begin
      f_t = rb ^ rc ^ rd;
      k_t = ROUND_K[1];
    end else if (t < 7'd60) begin
      f_t = (rb & rc) | (rb & rd) | (rc & rd);
      k_t = ROUND_K[2];
    end else begin
      f_t = rb ^ rc ^ rd;
      k_t = ROUND_K[3];
    end
  end

  assign tmp = {ra[26:0], ra[31:27]} + f_t + re + w_t + k_t;

  // Buffer, round registers, digest buffer contents
  always_ff @(posedge clk) begin
    if (cmd.round_step) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BLK_WORDS-1] <= w_t;
    end else if (cmd.put_byte) begin
      win[idx] <= word_new;
    end

    if (cmd.load_rounds) begin
      ra <= h[0];
      rb <= h[1];
      rc <= h[2];
      rd <= h[3];
      re <= h[4];
      t  <= '0;
    end else if (cmd.round_step) begin
      ra <= tmp;
      rb <= ra;
      rc <= {rb[1:0], rb[31:2]};
      rd <= rc;
      re <= rd;
      t  <= t + 7'd1;
    end

    if (cmd.load_out) begin
      for (int i = 0; i < NUM_H; i++) begin
        obuf[i] <= h[i];
      end
    end else if (ovalid && out_ready) begin
      for (int i = 0; i < NUM_H - 1; i++) begin
        obuf[i] <= obuf[i+1];
      end
    end
  end

  // Length, fill position, chaining words, output flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      bit_length <= '0;
      ovalid     <= 1'b0;
      onum       <= '0;
      for (int i = 0; i < NUM_H; i++) begin
        h[i] <= INIT_H[i];
      end
    end else begin
      if (cmd.load_out) begin
        // digest copied out; start a new message
        pos        <= '0;
        bit_length <= '0;
        for (int i = 0; i < NUM_H; i++) begin
          h[i] <= INIT_H[i];
        end
        ovalid <= 1'b1;
        onum   <= '0;
      end else begin
        if (cmd.put_byte) begin
          pos <= pos + 6'd1;
        end
        if (cmd.count_len) begin
          bit_length <= bit_length + 64'd8;
        end
        if (cmd.add_chain) begin
          h[0] <= h[0] + ra;
          h[1] <= h[1] + rb;
          h[2] <= h[2] + rc;
          h[3] <= h[3] + rd;
          h[4] <= h[4] + re;
        end
        if (ovalid && out_ready) begin
          onum <= onum + 3'd1;
          if (onum == LAST_WORD) begin
            ovalid <= 1'b0;
          end
        end
      end
    end
  end

  assign stat.pos_last   = (pos == BLOCK_LAST_POS);
  assign stat.pos_len    = (pos == LEN_POS);
  assign stat.round_last = (t == ROUND_LAST);
  assign stat.out_busy   = ovalid;

  assign out_valid   = ovalid;
  assign digest_word = obuf[0];
  assign word_number = onum;
  assign final_word  = (onum == LAST_WORD);

endmodule

>>> rtl/sha0_ctrl.sv
// Controller: absorb, padding sequence, compression rounds and digest hand-off.
module sha0_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  output sha0_pkg::dp_cmd_t  cmd,
  input  sha0_pkg::dp_stat_t stat
);
  import sha0_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_PAD80  = 8'b00000010,
    S_PADZ   = 8'b00000100,
    S_PADLEN = 8'b00001000,
    S_LOAD   = 8'b00010000,
    S_ROUND  = 8'b00100000,
    S_ADD    = 8'b01000000,
    S_EMIT   = 8'b10000000
  } state_t;

  state_t state, state_next;
  state_t resume, resume_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    resume_next = resume;
    cmd         = '0;
    cmd.byte_sel = BSEL_IN;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (operation) begin
            state_next = S_PAD80;
          end else begin
            cmd.put_byte  = 1'b1;
            cmd.count_len = 1'b1;
            if (stat.pos_last) begin
              state_next  = S_LOAD;
              resume_next = S_IDLE;
            end
          end
        end
      end
      S_PAD80: begin
        cmd.put_byte = 1'b1;
        cmd.byte_sel = BSEL_PAD;
        state_next   = S_PADZ;
        if (stat.pos_last) begin
          state_next  = S_LOAD;
          resume_next = S_PADZ;
        end
      end
      S_PADZ: begin
        // zero fill up to the length field, spilling into a second block if needed
        if (stat.pos_len) begin
          state_next = S_PADLEN;
        end else begin
          cmd.put_byte = 1'b1;
          cmd.byte_sel = BSEL_ZERO;
          if (stat.pos_last) begin
            state_next  = S_LOAD;
            resume_next = S_PADZ;
          end
        end
      end
      S_PADLEN: begin
        cmd.put_byte = 1'b1;
        cmd.byte_sel = BSEL_LEN;
        if (stat.pos_last) begin
          state_next  = S_LOAD;
          resume_next = S_EMIT;
        end
      end
      S_LOAD: begin
        cmd.load_rounds = 1'b1;
        state_next      = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (stat.round_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        state_next    = resume;
      end
      S_EMIT: begin
        // wait for the previous digest to drain
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      resume <= S_IDLE;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

endmodule

>>> rtl/sha0_byte_stream_hasher_unit.sv
// Top level: SHA-0 byte stream hasher, controller plus datapath.
// Absorb: one byte per cycle when idle; the 64th byte starts load, 80 rounds and chaining add.
// Finish: the finish word is taken, then the 0x80 pad byte, the zero fill, a step into the
// length field and the length bytes are placed, with one or two compressions; the digest buffer
// loads once the previous digest has drained, and its 5 words drain as the next message is absorbed.
// Synchronous active-high reset loads h0..h4, clears bit length, fill position, output valid.
module sha0_byte_stream_hasher_unit (
  input  logic     clk,
  input  logic     rst,
  sha0_in_if.sink    in_ch,
  sha0_out_if.source out_ch
);
  import sha0_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha0_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .operation (in_ch.operation),
    .cmd       (cmd),
    .stat      (stat)
  );

  sha0_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .message_byte (in_ch.message_byte),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .digest_word  (out_ch.digest_word),
    .word_number  (out_ch.word_number),
    .final_word   (out_ch.final_word)
  );

endmodule
